// ----- hdl/scsp_pkg.sv -----
`default_nettype none

package scsp_pkg;

	// segment layout
	localparam int HEADER_BYTES = 11;
	localparam int OBJECT_BYTES = 8;
	localparam int WORD_COUNT   = 7;
	localparam int BYTE_COUNT   = 3;

	// field offset counter covers a cropped object, the longest unit
	localparam int OFFSET_BITS = $clog2(2 * OBJECT_BYTES);

	localparam logic [OFFSET_BITS-1:0] HDR_LAST_OFFSET   = OFFSET_BITS'(HEADER_BYTES - 1);
	localparam logic [OFFSET_BITS-1:0] OBJ_LAST_PLAIN    = OFFSET_BITS'(OBJECT_BYTES - 1);
	localparam logic [OFFSET_BITS-1:0] OBJ_LAST_CROPPED  = OFFSET_BITS'(2 * OBJECT_BYTES - 1);

	// marker byte values
	localparam logic [7:0] CROP_MARK           = 8'h40;
	localparam logic [7:0] PALETTE_UPDATE_MARK = 8'h80;

	// result kinds
	localparam logic [2:0] KIND_HEADER        = 3'd0;
	localparam logic [2:0] KIND_OBJECT        = 3'd1;
	localparam logic [2:0] KIND_HEADER_SHORT  = 3'd2;
	localparam logic [2:0] KIND_OBJECTS_SHORT = 3'd3;
	localparam logic [2:0] KIND_OBJECT_TRUNC  = 3'd4;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic        segment_start;
		logic [15:0] segment_size;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [15:0] word_zero;
		logic [15:0] word_one;
		logic [15:0] word_two;
		logic [15:0] word_three;
		logic [15:0] word_four;
		logic [15:0] word_five;
		logic [15:0] word_six;
		logic [7:0]  byte_zero;
		logic [7:0]  byte_one;
		logic [7:0]  byte_two;
		logic        flag_bit;
	} result_item_t;

	// registered input item handed to the parser
	typedef struct packed {
		logic       valid;
		byte_item_t item;
	} stage_item_t;

	// parser outcome for one step
	typedef struct packed {
		logic         valid;
		result_item_t item;
	} parse_out_t;

endpackage

`default_nettype wire

// ----- hdl/scsp_input_stage.sv -----
`default_nettype none

module scsp_input_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire scsp_pkg::byte_item_t byte_item,
	input  wire logic                 advance,
	output scsp_pkg::stage_item_t     stage_s1
);
	import scsp_pkg::*;

	logic       valid_s1;
	byte_item_t item_s1;

	// hold the registered item while the parser cannot advance
	assign byte_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	assign stage_s1.valid = valid_s1;
	assign stage_s1.item  = item_s1;

endmodule

`default_nettype wire

// ----- hdl/scsp_field_parser.sv -----
`default_nettype none

module scsp_field_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire scsp_pkg::byte_item_t  item,
	output scsp_pkg::parse_out_t       pout
);
	import scsp_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_OBJECT
	} phase_t;

	// parse state
	phase_t                 phase_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [15:0]            left_q;
	logic [7:0]             objs_q;
	logic [15:0]            words_q [WORD_COUNT];
	logic [7:0]             bytes_q [BYTE_COUNT];
	logic                   crop_q;

	// next state
	phase_t                 phase_n;
	logic [OFFSET_BITS-1:0] offset_n;
	logic [15:0]            left_n;
	logic [7:0]             objs_n;
	logic [15:0]            words_n [WORD_COUNT];
	logic [7:0]             bytes_n [BYTE_COUNT];
	logic                   crop_n;

	logic [15:0]            left_at_byte;
	logic [7:0]             b;
	logic                   res_valid;
	logic                   res_fields;
	logic [2:0]             res_kind;
	result_item_t           res_item;

	assign b = item.byte_value;

	// one byte of parsing
	always_comb begin
		phase_n      = phase_q;
		offset_n     = offset_q;
		left_n       = left_q;
		objs_n       = objs_q;
		words_n      = words_q;
		bytes_n      = bytes_q;
		crop_n       = crop_q;
		left_at_byte = '0;
		res_valid    = 1'b0;
		res_fields   = 1'b0;
		res_kind     = KIND_HEADER;

		// segment start drops any parse in progress
		if (item.segment_start) begin
			offset_n = '0;
			objs_n   = '0;
			for (int i = 0; i < WORD_COUNT; i++) words_n[i] = '0;
			for (int i = 0; i < BYTE_COUNT; i++) bytes_n[i] = '0;
			crop_n = 1'b0;
			if (item.segment_size < 16'(HEADER_BYTES)) begin
				left_n    = '0;
				phase_n   = PH_IDLE;
				res_valid = 1'b1;
				res_kind  = KIND_HEADER_SHORT;
			end else begin
				left_n  = item.segment_size;
				phase_n = PH_HEADER;
			end
		end

		left_at_byte = left_n;
		if (phase_n != PH_IDLE && left_n != '0) begin
			left_n = left_n - 16'd1;
		end

		case (phase_n)
			PH_IDLE: begin
			end
			PH_HEADER: begin
				// header field assembly, big-endian
				case (offset_n)
					4'd0, 4'd1: words_n[0] = {words_n[0][7:0], b};
					4'd2, 4'd3: words_n[1] = {words_n[1][7:0], b};
					4'd4:       bytes_n[0] = b;
					4'd5, 4'd6: words_n[2] = {words_n[2][7:0], b};
					4'd7:       bytes_n[1] = b;
					4'd8:       crop_n     = (b == PALETTE_UPDATE_MARK);
					4'd9:       bytes_n[2] = b;
					default: begin
					end
				endcase
				if (offset_n < HDR_LAST_OFFSET) begin
					offset_n = offset_n + OFFSET_BITS'(1);
				end else begin
					// last header byte carries the object count
					objs_n     = b;
					words_n[3] = {8'd0, b};
					res_valid  = 1'b1;
					if (left_n < 16'(16'(b) * 16'(OBJECT_BYTES))) begin
						res_kind = KIND_OBJECTS_SHORT;
						phase_n  = PH_IDLE;
					end else begin
						res_kind   = KIND_HEADER;
						res_fields = 1'b1;
						offset_n   = '0;
						phase_n    = (b == 8'd0) ? PH_IDLE : PH_OBJECT;
					end
				end
			end
			PH_OBJECT: begin
				if (offset_n == '0 && left_at_byte < 16'(OBJECT_BYTES)) begin
					res_valid = 1'b1;
					res_kind  = KIND_OBJECT_TRUNC;
					phase_n   = PH_IDLE;
				end else begin
					case (offset_n)
						4'd0, 4'd1:   words_n[0] = {words_n[0][7:0], b};
						4'd2:         bytes_n[0] = b;
						4'd3:         crop_n     = (b == CROP_MARK);
						4'd4, 4'd5:   words_n[1] = {words_n[1][7:0], b};
						4'd6, 4'd7:   words_n[2] = {words_n[2][7:0], b};
						4'd8, 4'd9:   words_n[3] = {words_n[3][7:0], b};
						4'd10, 4'd11: words_n[4] = {words_n[4][7:0], b};
						4'd12, 4'd13: words_n[5] = {words_n[5][7:0], b};
						default:      words_n[6] = {words_n[6][7:0], b};
					endcase
					// cropped object needs twice the bytes from its start
					if (offset_n == 4'd3 && crop_n &&
					    (17'(left_at_byte) + 17'd3) < 17'(2 * OBJECT_BYTES)) begin
						res_valid = 1'b1;
						res_kind  = KIND_OBJECT_TRUNC;
						phase_n   = PH_IDLE;
					end else if (offset_n < (crop_n ? OBJ_LAST_CROPPED : OBJ_LAST_PLAIN)) begin
						offset_n = offset_n + OFFSET_BITS'(1);
					end else begin
						res_valid  = 1'b1;
						res_kind   = KIND_OBJECT;
						res_fields = 1'b1;
						offset_n   = '0;
						objs_n     = objs_n - 8'd1;
						if (objs_n == 8'd0) begin
							phase_n = PH_IDLE;
						end
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

	// result fields, all zero on an error
	always_comb begin
		res_item             = '0;
		res_item.result_kind = res_kind;
		if (res_fields) begin
			res_item.word_zero  = words_n[0];
			res_item.word_one   = words_n[1];
			res_item.word_two   = words_n[2];
			res_item.word_three = words_n[3];
			res_item.word_four  = words_n[4];
			res_item.word_five  = words_n[5];
			res_item.word_six   = words_n[6];
			res_item.byte_zero  = bytes_n[0];
			res_item.byte_one   = bytes_n[1];
			res_item.byte_two   = bytes_n[2];
			res_item.flag_bit   = crop_n;
		end
	end

	assign pout.valid = step && res_valid;
	assign pout.item  = res_item;

	// state registers; fields clear after each emitted header or object
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			offset_q <= '0;
			left_q   <= '0;
			objs_q   <= '0;
			crop_q   <= 1'b0;
			for (int i = 0; i < WORD_COUNT; i++) words_q[i] <= '0;
			for (int i = 0; i < BYTE_COUNT; i++) bytes_q[i] <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			offset_q <= offset_n;
			left_q   <= left_n;
			objs_q   <= objs_n;
			if (res_fields) begin
				crop_q <= 1'b0;
				for (int i = 0; i < WORD_COUNT; i++) words_q[i] <= '0;
				for (int i = 0; i < BYTE_COUNT; i++) bytes_q[i] <= '0;
			end else begin
				crop_q  <= crop_n;
				words_q <= words_n;
				bytes_q <= bytes_n;
			end
		end
	end

	// error results always leave the parser idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res_kind != KIND_HEADER && res_kind != KIND_OBJECT)
		|=> (phase_q == PH_IDLE))
		else $error("parser not idle after error item");

	// header offset never runs past the last header byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (offset_q <= HDR_LAST_OFFSET))
		else $error("header offset out of range");

	// object phase always has an object pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_OBJECT) |-> (objs_q != 8'd0))
		else $error("object phase with no objects left");

	// uncropped object stays within its plain length
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_OBJECT && !crop_q) |-> (offset_q <= OBJ_LAST_PLAIN))
		else $error("uncropped object offset out of range");

endmodule

`default_nettype wire

// ----- hdl/scsp_result_stage.sv -----
`default_nettype none

module scsp_result_stage (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire scsp_pkg::parse_out_t   pout,
	output logic                        advance,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output scsp_pkg::result_item_t      result_item
);
	import scsp_pkg::*;

	logic         valid_q;
	result_item_t item_q;

	// result register frees up when empty or being taken
	assign advance = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= pout.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pout.valid) begin
			item_q <= pout.item;
		end
	end

	assign result_valid = valid_q;
	assign result_item  = item_q;

endmodule

`default_nettype wire

// ----- hdl/subtitle_composition_segment_parser_core.sv -----
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------
// byte     | byte_valid / byte_stall    | byte_item   (byte_item_t)
// result   | result_valid / result_stall| result_item (result_item_t)
//
// one byte item per cycle unless stalled; a byte's result is registered in the result register
// the rate is set by the combinational parse step between input and result registers
// arst_n clears the parse phase, counters and fields; the block then waits for a segment start
// a stalled result holds the result register, which in turn holds the input register
// bytes that produce no result still pass through the parse step in order

`default_nettype none

module subtitle_composition_segment_parser_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_stall,
	input  wire scsp_pkg::byte_item_t   byte_item,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output scsp_pkg::result_item_t      result_item
);
	import scsp_pkg::*;

	stage_item_t stage_s1;
	parse_out_t  pout;
	logic        advance;

	// input register
	scsp_input_stage u_input (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.advance    (advance),
		.stage_s1   (stage_s1)
	);

	// parse step
	scsp_field_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (stage_s1.valid && advance),
		.item   (stage_s1.item),
		.pout   (pout)
	);

	// result register
	scsp_result_stage u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.pout         (pout),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

`default_nettype wire
